/* rtl/core/lhp_pkg.sv */
// Shared types and constants of the latency histogram percentile unit.
// Holds the bucket bound table, operation codes and the bound lookup.
// No dependencies.
package lhp_pkg;

  localparam int TABLE_BOUNDS = 12;
  localparam int MAX_IDX_W    = 5;
  localparam int SAMPLE_W     = 32;
  localparam int TOTAL_W      = 48;
  localparam int FRAC_W       = 17;
  localparam int PROD_W       = SAMPLE_W + FRAC_W;
  localparam int TARGET_W     = PROD_W - 16;

  localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef logic [SAMPLE_W-1:0] bound_t;

  localparam bound_t BOUND_TABLE [TABLE_BOUNDS] = '{
    32'd50, 32'd100, 32'd250, 32'd500, 32'd1000, 32'd2000,
    32'd4000, 32'd8000, 32'd16000, 32'd33000, 32'd66000, 32'd100000
  };

  // Bounds past the table repeat its largest entry.
  function automatic bound_t upper_bound(input logic [MAX_IDX_W-1:0] idx);
    bound_t b;
    b = BOUND_TABLE[TABLE_BOUNDS-1];
    if (idx < MAX_IDX_W'(TABLE_BOUNDS)) begin
      b = BOUND_TABLE[idx[3:0]];
    end
    return b;
  endfunction

endpackage

/* rtl/core/latency_histogram_percentile_unit.sv */
// Latency histogram and percentile estimator: scalar counters in flops,
// bucket tallies in a one-port-read synchronous memory. Uses lhp_pkg.
// Record: busy after the transfer through the tally write-back state; no new transfer is taken until then.
// Query: busy after the transfer through S_Q_MUL, S_Q_TGT and a walk of k = 1..BUCKET_COUNT buckets,
// one memory read per cycle; the strobe is registered as the walk ends, as busy drops.
// Synchronous reset clears all counters and marks every tally entry empty.
module latency_histogram_percentile_unit
  import lhp_pkg::*;
#(
  parameter int BUCKET_COUNT = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [SAMPLE_W-1:0]   in_sample_us,
  input  logic [FRAC_W-1:0]     in_percentile_fraction,
  output logic                  out_valid,
  output logic [SAMPLE_W-1:0]   out_percentile_bound_us,
  output logic [SAMPLE_W-1:0]   out_sample_count,
  output logic [TOTAL_W-1:0]    out_total_us,
  output logic [SAMPLE_W-1:0]   out_maximum_us
);

  localparam int IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int CUM_W = SAMPLE_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC_WB,
    S_Q_MUL,
    S_Q_TGT,
    S_Q_WALK
  } state_t;

  state_t                 state_r;
  logic [SAMPLE_W-1:0]    count_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [SAMPLE_W-1:0]    max_r;
  logic [FRAC_W-1:0]      frac_r;
  logic [PROD_W-1:0]      prod_r;
  logic [TARGET_W-1:0]    target_r;
  logic [CUM_W-1:0]       cum_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   out_valid_r;
  logic [SAMPLE_W-1:0]    out_bound_r;
  logic [SAMPLE_W-1:0]    out_count_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic [SAMPLE_W-1:0]    out_max_r;

  // Tally store
  logic [SAMPLE_W-1:0]    tally_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] vld_r;
  logic [SAMPLE_W-1:0]    rd_data_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [SAMPLE_W-1:0]    tally_nxt;

  logic                   accept;
  logic [IDX_W-1:0]       pick_idx;
  logic [SAMPLE_W-1:0]    count_nxt;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_nxt;
  logic [FRAC_W-1:0]      frac_sat;
  logic [PROD_W-1:0]      tgt_sum;
  logic [TARGET_W-1:0]    target_nxt;
  logic [SAMPLE_W-1:0]    tally_rd;
  logic [CUM_W-1:0]       cum_nxt;
  logic                   hit;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // First bucket whose bound covers the sample; scan from the top so the
  // lowest matching index wins.
  always_comb begin
    pick_idx = LAST_IDX;
    for (int i = BUCKET_COUNT - 2; i >= 0; i--) begin
      if (upper_bound(MAX_IDX_W'(i)) >= in_sample_us) begin
        pick_idx = IDX_W'(i);
      end
    end
  end

  assign count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
  assign total_sum = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(in_sample_us);
  assign total_nxt = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
  assign frac_sat  = (in_percentile_fraction > Q16_ONE) ? Q16_ONE : in_percentile_fraction;

  assign tgt_sum    = prod_r + PROD_W'(Q16_ONE - 1'b1);
  assign target_nxt = (tgt_sum[PROD_W-1:16] == '0) ? TARGET_W'(1) : tgt_sum[PROD_W-1:16];

  // Entries never written read as zero.
  assign tally_rd  = rd_vld_r ? rd_data_r : '0;
  assign tally_nxt = (tally_rd == '1) ? tally_rd : tally_rd + 1'b1;
  assign cum_nxt   = cum_r + CUM_W'(tally_rd);
  assign hit       = (cum_nxt >= CUM_W'(target_r));
  assign wr_en     = (state_r == S_REC_WB);

  always_comb begin
    rd_addr = '0;
    if (state_r == S_IDLE) begin
      rd_addr = pick_idx;
    end else if (state_r == S_Q_WALK && idx_r != LAST_IDX) begin
      rd_addr = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tally_mem[idx_r] <= tally_nxt;
    end
    rd_data_r <= tally_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_RECORD) begin
              count_r <= count_nxt;
              total_r <= total_nxt;
              if (in_sample_us > max_r) begin
                max_r <= in_sample_us;
              end
              idx_r   <= pick_idx;
              state_r <= S_REC_WB;
            end else begin
              frac_r  <= frac_sat;
              state_r <= S_Q_MUL;
            end
          end
        end
        S_REC_WB: begin
          state_r <= S_IDLE;
        end
        S_Q_MUL: begin
          prod_r  <= PROD_W'(count_r) * PROD_W'(frac_r);
          state_r <= S_Q_TGT;
        end
        S_Q_TGT: begin
          // read of bucket zero issued here
          target_r <= target_nxt;
          cum_r    <= '0;
          idx_r    <= '0;
          state_r  <= S_Q_WALK;
        end
        S_Q_WALK: begin
          cum_r <= cum_nxt;
          if (hit || idx_r == LAST_IDX) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_r;
            out_total_r <= total_r;
            out_max_r   <= max_r;
            if (count_r == '0) begin
              out_bound_r <= '0;
            end else if (hit && idx_r != LAST_IDX) begin
              out_bound_r <= upper_bound(MAX_IDX_W'(idx_r));
            end else begin
              out_bound_r <= max_r;
            end
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_percentile_bound_us = out_bound_r;
  assign out_sample_count        = out_count_r;
  assign out_total_us            = out_total_r;
  assign out_maximum_us          = out_max_r;

`ifndef SYNTHESIS
  a_strobe_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_Q_WALK))
    else $error("result strobe without a finished bucket walk");

  a_record_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_RECORD) |=> (wr_en && !out_valid_r))
    else $error("record transfer not followed by tally write-back");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("sample count decreased");

  a_empty_bound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == '0) |-> (out_bound_r == '0 && out_max_r == '0))
    else $error("empty histogram reported a nonzero bound");
`endif

endmodule
